FILE: design/coalescing_alarm_log_defines.svh
// assertion macros for the alarm log
`ifndef COALESCING_ALARM_LOG_DEFINES_SVH
`define COALESCING_ALARM_LOG_DEFINES_SVH

// property must hold at every edge outside reset
`define CAL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cal_pkg.sv
package cal_pkg;

  localparam int LOG_DEPTH = 16;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_SCAN  = 3'd2,
    OP_WRITE = 3'd3,
    OP_SORT  = 3'd4,
    OP_TOP   = 3'd5,
    OP_OUT   = 3'd6
  } dp_op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  event_source;
    logic [7:0]  event_kind;
    logic [7:0]  event_severity;
    logic [47:0] event_time;
    logic [47:0] event_duration;
    logic [3:0]  read_rank;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic        merged;
    logic        move_down;
    logic [4:0]  fill_count;
    logic [31:0] entry_id;
    logic [7:0]  out_source;
    logic [7:0]  out_kind;
    logic [7:0]  out_severity;
    logic [47:0] out_time;
    logic [48:0] out_duration;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    dp_op_e           op;
    logic [CNT_W-1:0] idx;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             match;
  } sts_t;

endpackage

FILE: design/cal_evt_if.sv
interface cal_evt_if;
  logic               valid;
  logic               ready;
  cal_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/cal_res_if.sv
interface cal_res_if;
  logic               valid;
  logic               ready;
  cal_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/coalescing_alarm_log.sv
// Ranked alarm log with coalescing of repeated active alarms.
// evt_i carries one command word (add, read at rank, clear); res_o returns
// exactly one result word per command, in order, valid/ready on both sides.
// cfg_we_i/cfg_data_i write sort_by_severity; a new mode applies at the
// next add, existing ranks are not rebuilt on the write.
// Sequence: read, clear and unused commands go from the accept straight to
// the result register. An add scans the entries for a match (up to the
// fill count, stopping at the first hit), writes, re-ranks every entry with
// the one-rank-per-cycle insertion sort, then evaluates the top entry.
// A new word is taken only once the previous one has been handed to the
// result register; while the receiver stalls the finished result waits
// there and the next word is still accepted and worked on, then holds
// until the register frees.
// Reset empties the log, zeroes the id counter and the remembered top
// entry, and selects age ranking; entry contents need no clearing.
`include "coalescing_alarm_log_defines.svh"

module coalescing_alarm_log (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  cal_evt_if.sink   evt_i,
  cal_res_if.source res_o
);

  cal_pkg::ctl_t ctl;
  cal_pkg::sts_t sts;

  // sequencer
  cal_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (evt_i.valid),
    .in_command_i (evt_i.data.command),
    .out_ready_i  (res_o.ready),
    .sts_i        (sts),
    .in_ready_o   (evt_i.ready),
    .out_valid_o  (res_o.valid),
    .ctl_o        (ctl)
  );

  // log store, matcher and ranker
  cal_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (evt_i.data),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_word_o (res_o.data)
  );

  // checks
  `CAL_ASSERT(a_count_bound, clk_i, rst_ni, sts.count <= cal_pkg::CNT_W'(cal_pkg::LOG_DEPTH), "fill count beyond depth")
  `CAL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, evt_i.valid && evt_i.ready, !evt_i.ready, "accepted while busy")
  `CAL_ASSERT(a_sort_in_range, clk_i, rst_ni, (ctl.op != cal_pkg::OP_SORT) || (ctl.idx < sts.count), "rank index past fill")

endmodule

FILE: design/cal_ctrl.sv
module cal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_command_i,
  input  logic          out_ready_i,
  input  cal_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output cal_pkg::ctl_t ctl_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WRITE = 6'b000100,
    S_SORT  = 6'b001000,
    S_TOP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  logic [cal_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;
  logic                      last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign last        = (idx_q + cal_pkg::CNT_W'(1)) >= sts_i.count;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ctl_o.idx   = idx_q;

  // next state and datapath command
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctl_o.op    = cal_pkg::OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = cal_pkg::OP_LOAD;
          idx_d    = '0;
          if (cal_pkg::cmd_e'(in_command_i) != cal_pkg::CMD_ADD) begin
            state_d = S_DONE;
          end else if (sts_i.count == '0) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl_o.op = cal_pkg::OP_SCAN;
        idx_d    = idx_q + cal_pkg::CNT_W'(1);
        if (sts_i.match || last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ctl_o.op = cal_pkg::OP_WRITE;
        idx_d    = '0;
        state_d  = S_SORT;
      end
      S_SORT: begin
        ctl_o.op = cal_pkg::OP_SORT;
        idx_d    = idx_q + cal_pkg::CNT_W'(1);
        if (last) begin
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        ctl_o.op = cal_pkg::OP_TOP;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl_o.op    = cal_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/cal_datapath.sv
module cal_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  cal_pkg::in_word_t  in_word_i,
  input  cal_pkg::ctl_t      ctl_i,
  output cal_pkg::sts_t      sts_o,
  output cal_pkg::out_word_t out_word_o
);

  localparam int IW = cal_pkg::IDX_W;
  localparam int CW = cal_pkg::CNT_W;
  localparam int D  = cal_pkg::LOG_DEPTH;

  // entry store
  logic [7:0]  src_q [D];
  logic [7:0]  kind_q [D];
  logic [7:0]  sev_q [D];
  logic [47:0] start_q [D];
  logic [48:0] len_q [D];
  logic [31:0] ident_q [D];

  // ranking and its cached severities
  logic [IW-1:0] rank_q [D];
  logic [7:0]    rsev_q [D];

  logic [IW-1:0]   head_q;
  logic [CW-1:0]   count_q;
  logic [31:0]     last_id_q;
  logic [15:0]     prev_top_q;
  logic            sort_q;
  logic            move_q;
  logic            found_q;
  logic            later_q;
  logic [47:0]     gap_q;
  logic [IW-1:0]   sel_q;
  cal_pkg::in_word_t word_q;
  cal_pkg::out_word_t out_q;
  cal_pkg::out_word_t out_d;

  logic [CW:0]     age_sum;
  logic [IW-1:0]   age_slot;
  logic [IW-1:0]   rd_slot;
  logic [IW-1:0]   rank_ix;
  logic            rank_ok;
  logic [49:0]     end_time;
  logic            match;
  logic [D-1:0]    ge;
  logic [CW-1:0]   ins_pos;
  logic [IW-1:0]   new_head;
  logic [31:0]     next_id;
  logic            is_read;

  // slot of the entry at age idx
  always_comb begin
    age_sum = (CW + 1)'(head_q) + (CW + 1)'(ctl_i.idx);
    if (age_sum >= (CW + 1)'(D)) begin
      age_sum = age_sum - (CW + 1)'(D);
    end
    age_slot = age_sum[IW-1:0];
  end

  assign is_read = cal_pkg::cmd_e'(word_q.command) == cal_pkg::CMD_READ;
  assign rank_ix = IW'(word_q.read_rank);
  assign rank_ok = (CW'(word_q.read_rank) < count_q) &&
                   ((CW + 4)'(word_q.read_rank) < (CW + 4)'(D));

  // single read address into the entry store
  always_comb begin
    case (ctl_i.op)
      cal_pkg::OP_SCAN, cal_pkg::OP_SORT: rd_slot = age_slot;
      cal_pkg::OP_TOP:                    rd_slot = rank_q[0];
      default:                            rd_slot = is_read ? rank_q[rank_ix] : sel_q;
    endcase
  end

  // active-entry match
  assign end_time = 50'(start_q[rd_slot]) + 50'(len_q[rd_slot]);
  assign match    = (src_q[rd_slot] == word_q.event_source) &&
                    (kind_q[rd_slot] == word_q.event_kind) &&
                    (end_time > 50'(word_q.event_time));

  // stable insertion position among ranks already placed
  always_comb begin
    for (int j = 0; j < D; j++) begin
      ge[j] = (CW'(j) < ctl_i.idx) && (rsev_q[j] >= sev_q[rd_slot]);
    end
    ins_pos = sort_q ? CW'($countones(ge)) : ctl_i.idx;
  end

  assign new_head = (head_q == '0) ? IW'(D - 1) : head_q - IW'(1);
  assign next_id  = (last_id_q + 32'd1 == 32'd0) ? 32'd1 : last_id_q + 32'd1;

  assign sts_o.count  = count_q;
  assign sts_o.match  = match;
  assign out_word_o   = out_q;

  // result word for the current command
  always_comb begin
    out_d            = '0;
    out_d.fill_count = 5'(count_q);
    case (cal_pkg::cmd_e'(word_q.command))
      cal_pkg::CMD_ADD: begin
        out_d.hit          = 1'b1;
        out_d.merged       = found_q;
        out_d.move_down    = move_q;
        out_d.entry_id     = ident_q[rd_slot];
        out_d.out_source   = src_q[rd_slot];
        out_d.out_kind     = kind_q[rd_slot];
        out_d.out_severity = sev_q[rd_slot];
        out_d.out_time     = start_q[rd_slot];
        out_d.out_duration = len_q[rd_slot];
      end
      cal_pkg::CMD_READ: begin
        if (rank_ok) begin
          out_d.hit          = 1'b1;
          out_d.entry_id     = ident_q[rd_slot];
          out_d.out_source   = src_q[rd_slot];
          out_d.out_kind     = kind_q[rd_slot];
          out_d.out_severity = sev_q[rd_slot];
          out_d.out_time     = start_q[rd_slot];
          out_d.out_duration = len_q[rd_slot];
        end
      end
      cal_pkg::CMD_CLEAR: out_d.fill_count = '0;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      last_id_q  <= '0;
      prev_top_q <= '0;
      sort_q     <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sort_q <= cfg_data_i;
      end
      case (ctl_i.op)
        cal_pkg::OP_LOAD: found_q <= 1'b0;
        cal_pkg::OP_SCAN: begin
          if (match) begin
            found_q <= 1'b1;
          end
        end
        cal_pkg::OP_WRITE: begin
          if (!found_q) begin
            head_q    <= new_head;
            last_id_q <= next_id;
            if (count_q < CW'(D)) begin
              count_q <= count_q + CW'(1);
            end
          end
        end
        cal_pkg::OP_TOP: begin
          if (sort_q) begin
            prev_top_q <= {src_q[rd_slot], kind_q[rd_slot]};
          end
        end
        cal_pkg::OP_OUT: begin
          if (cal_pkg::cmd_e'(word_q.command) == cal_pkg::CMD_CLEAR) begin
            head_q  <= '0;
            count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: entry store, ranking, work registers, result word
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      cal_pkg::OP_LOAD: word_q <= in_word_i;
      cal_pkg::OP_SCAN: begin
        if (match) begin
          sel_q   <= rd_slot;
          later_q <= word_q.event_time > start_q[rd_slot];
          gap_q   <= word_q.event_time - start_q[rd_slot];
        end
      end
      cal_pkg::OP_WRITE: begin
        if (found_q) begin
          sev_q[sel_q] <= word_q.event_severity;
          if (later_q) begin
            len_q[sel_q] <= 49'(word_q.event_duration) + 49'(gap_q);
          end
        end else begin
          sel_q             <= new_head;
          src_q[new_head]   <= word_q.event_source;
          kind_q[new_head]  <= word_q.event_kind;
          sev_q[new_head]   <= word_q.event_severity;
          start_q[new_head] <= word_q.event_time;
          len_q[new_head]   <= 49'(word_q.event_duration);
          ident_q[new_head] <= next_id;
        end
      end
      cal_pkg::OP_SORT: begin
        for (int j = 0; j < D; j++) begin
          if (CW'(j) == ins_pos) begin
            rank_q[j] <= rd_slot;
            rsev_q[j] <= sev_q[rd_slot];
          end else if (j > 0 && CW'(j) > ins_pos && CW'(j) <= ctl_i.idx) begin
            rank_q[j] <= rank_q[j-1];
            rsev_q[j] <= rsev_q[j-1];
          end
        end
      end
      cal_pkg::OP_TOP: begin
        move_q <= !sort_q || ({src_q[rd_slot], kind_q[rd_slot]} != prev_top_q);
      end
      cal_pkg::OP_OUT: out_q <= out_d;
      default: ;
    endcase
  end

endmodule
